@@ design/sctdt_pkg.sv @@
// Package for the second-count to calendar date and time converter.
// Holds the sequencer state type, the time and calendar constants and the
// month length function. Depends on nothing.
`default_nettype none

package sctdt_pkg;

  localparam int unsigned WORK_W = 34;

  localparam logic [WORK_W-1:0] DAY_SECS  = WORK_W'(86400);
  localparam logic [WORK_W-1:0] HOUR_SECS = WORK_W'(3600);
  localparam logic [WORK_W-1:0] MIN_SECS  = WORK_W'(60);

  localparam logic [11:0] EPOCH_YEAR = 12'd2000;
  localparam logic [8:0]  LEAP_YEAR_DAYS = 9'd366;
  localparam logic [8:0]  NORM_YEAR_DAYS = 9'd365;
  localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

  localparam logic [4:0] DAY_BITS_TOP  = 5'd16;
  localparam logic [4:0] HOUR_BITS_TOP = 5'd4;
  localparam logic [4:0] MIN_BITS_TOP  = 5'd5;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DAY   = 7'b0000010,
    ST_YEAR  = 7'b0000100,
    ST_MONTH = 7'b0001000,
    ST_HOUR  = 7'b0010000,
    ST_MIN   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // Month index counts from zero, so index one is February.
  function automatic logic [8:0] month_days(input logic [3:0] mon, input logic leap);
    logic [8:0] len;
    unique case (mon)
      4'd1: begin
        len = leap ? 9'd29 : 9'd28;
      end
      4'd3, 4'd5, 4'd8, 4'd10: begin
        len = 9'd30;
      end
      default: begin
        len = 9'd31;
      end
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ design/second_count_to_date_time_unit.sv @@
// Top level of the second-count to calendar date and time converter.
// Uses sctdt_pkg for its state type, constants and month length table.
// Contains the whole sequencer and its shared subtract-and-compare unit.
`default_nettype none

// Converts a count of seconds since 2000-01-01 00:00:00 into a Gregorian
// year, month, day, hour, minute and second. Whole days are split off first
// by a restoring division; the year follows by subtracting year lengths one
// year at a time, ending with a closing compare, and the month likewise
// month by month; restoring divisions then find the hour and the minute,
// and a last step hands over the result. All of it runs
// through a single 34-bit subtract-and-compare unit, so one item is worked
// on at a time; the next item is taken once the result sits in the output
// register, even if it has not been taken yet.
module second_count_to_date_time_unit
  import sctdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0: second_count[31:0].
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0: year_out[11:0], month_out[15:12], day_out[20:16],
  // hour_out[25:21], minute_out[31:26], second_out[37:32], zero fill.
  output logic [39:0]      out_tdata
);

  state_t            state_r, state_nxt;
  logic [WORK_W-1:0] num_r, num_nxt;
  logic [16:0]       quo_r, quo_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [11:0]       year_r, year_nxt;
  logic [1:0]        ymod4_r, ymod4_nxt;
  logic [6:0]        ymod100_r, ymod100_nxt;
  logic [8:0]        ymod400_r, ymod400_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [4:0]        day_r, day_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        minute_r, minute_nxt;
  logic [5:0]        second_r, second_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [39:0]       out_tdata_r, out_tdata_nxt;

  logic              leap;
  logic [8:0]        ylen;
  logic [8:0]        mlen;
  logic [WORK_W-1:0] sub_a, sub_b;
  logic [WORK_W:0]   diff;
  logic              ge;

  assign leap = (ymod400_r == 9'd0) || ((ymod4_r == 2'd0) && (ymod100_r != 7'd0));
  assign ylen = leap ? LEAP_YEAR_DAYS : NORM_YEAR_DAYS;
  assign mlen = month_days(mon_r, leap);

  always_comb begin
    sub_a = num_r;
    sub_b = '0;
    unique case (state_r)
      ST_DAY: begin
        sub_b = DAY_SECS << cnt_r;
      end
      ST_YEAR: begin
        sub_a = {{(WORK_W-17){1'b0}}, quo_r};
        sub_b = {{(WORK_W-9){1'b0}}, ylen};
      end
      ST_MONTH: begin
        sub_a = {{(WORK_W-17){1'b0}}, quo_r};
        sub_b = {{(WORK_W-9){1'b0}}, mlen};
      end
      ST_HOUR: begin
        sub_b = HOUR_SECS << cnt_r;
      end
      ST_MIN: begin
        sub_b = MIN_SECS << cnt_r;
      end
      default: begin
      end
    endcase
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[WORK_W];
  end

  always_comb begin
    state_nxt      = state_r;
    num_nxt        = num_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    year_nxt       = year_r;
    ymod4_nxt      = ymod4_r;
    ymod100_nxt    = ymod100_r;
    ymod400_nxt    = ymod400_r;
    mon_nxt        = mon_r;
    day_nxt        = day_r;
    hour_nxt       = hour_r;
    minute_nxt     = minute_r;
    second_nxt     = second_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          num_nxt     = {{(WORK_W-32){1'b0}}, in_tdata};
          quo_nxt     = '0;
          cnt_nxt     = DAY_BITS_TOP;
          year_nxt    = EPOCH_YEAR;
          ymod4_nxt   = '0;
          ymod100_nxt = '0;
          ymod400_nxt = '0;
          mon_nxt     = '0;
          state_nxt   = ST_DAY;
        end
      end
      ST_DAY: begin
        quo_nxt = {quo_r[15:0], ge};
        if (ge) begin
          num_nxt = diff[WORK_W-1:0];
        end
        if (cnt_r == 5'd0) begin
          state_nxt = ST_YEAR;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_YEAR: begin
        if (ge) begin
          quo_nxt     = diff[16:0];
          year_nxt    = year_r + 12'd1;
          ymod4_nxt   = ymod4_r + 2'd1;
          ymod100_nxt = (ymod100_r == 7'd99) ? 7'd0 : ymod100_r + 7'd1;
          ymod400_nxt = (ymod400_r == 9'd399) ? 9'd0 : ymod400_r + 9'd1;
        end else begin
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (ge && (mon_r != LAST_MONTH_IDX)) begin
          quo_nxt = diff[16:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          day_nxt   = quo_r[4:0] + 5'd1;
          quo_nxt   = '0;
          cnt_nxt   = HOUR_BITS_TOP;
          state_nxt = ST_HOUR;
        end
      end
      ST_HOUR: begin
        quo_nxt = {quo_r[15:0], ge};
        if (ge) begin
          num_nxt = diff[WORK_W-1:0];
        end
        if (cnt_r == 5'd0) begin
          hour_nxt  = quo_nxt[4:0];
          quo_nxt   = '0;
          cnt_nxt   = MIN_BITS_TOP;
          state_nxt = ST_MIN;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_MIN: begin
        quo_nxt = {quo_r[15:0], ge};
        if (ge) begin
          num_nxt = diff[WORK_W-1:0];
        end
        if (cnt_r == 5'd0) begin
          minute_nxt = quo_nxt[5:0];
          second_nxt = num_nxt[5:0];
          state_nxt  = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, second_r, minute_r, hour_r, day_r,
                            mon_r + 4'd1, year_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r       <= num_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    year_r      <= year_nxt;
    ymod4_r     <= ymod4_nxt;
    ymod100_r   <= ymod100_nxt;
    ymod400_r   <= ymod400_nxt;
    mon_r       <= mon_nxt;
    day_r       <= day_nxt;
    hour_r      <= hour_nxt;
    minute_r    <= minute_nxt;
    second_r    <= second_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // An accepted item always starts the day split.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DAY))
    else $error("accepted item did not start the day split");

  // A result is only loaded from the final state.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside the final state");

  // Month and time fields of a shown result stay within calendar range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[15:12] != 4'd0) && (out_tdata[15:12] <= 4'd12)
                    && (out_tdata[25:21] <= 5'd23) && (out_tdata[31:26] <= 6'd59)
                    && (out_tdata[37:32] <= 6'd59)))
    else $error("result field out of calendar range");

  // The month search never steps past December.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MONTH) |-> (mon_r <= LAST_MONTH_IDX))
    else $error("month index ran past December");

endmodule

`default_nettype wire
